// ===== hw/rtl/swmsd_pkg.sv =====
// swmsd_pkg: shared widths, types and control structs for the
// sliding window mean / stddev block. No dependencies.
`timescale 1ns / 1ps

package swmsd_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 24;  // signed Q15.8 sample and mean
  localparam int unsigned VAR_W      = 49;  // unsigned Q.16 variance
  localparam int unsigned SD_W       = 25;  // unsigned Q.8 standard deviation
  localparam int unsigned SQ_TERM_W  = 2 * SAMPLE_W;  // one squared deviation

  // square root datapath: radicand padded to an even width
  localparam int unsigned RAD_W      = 2 * SD_W;
  localparam int unsigned ROOT_REM_W = SD_W + 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // divider launch control
  typedef struct packed {
    logic start;       // load dividend and begin
    logic short_div;   // dividend is the narrow mean sum
  } div_ctrl_t;

endpackage

// ===== hw/rtl/sliding_window_mean_stddev.sv =====
// sliding_window_mean_stddev: moving-window mean, variance and stddev.
// Uses swmsd_pkg, swmsd_ring, swmsd_div and swmsd_sqrt.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one signed Q15.8 sample
//   per beat. Output channel (out_valid_o / out_ready_i) carries one result
//   beat per input: mean (Q15.8, truncated toward zero), variance (Q.16)
//   and standard deviation (Q.8) over all WINDOW ring slots.
//   One sample is in flight at a time. A result takes two passes over the
//   ring through its single read port plus pipeline drain, two runs of the
//   divider by WINDOW (2 and 4 digits of 16 bits, one digit per cycle) and
//   25 steps of the bit-serial square root.
//   Reset clears the write pointer and the per-slot written flags, so all
//   slots read as zero at once; the block is ready as soon as reset is
//   released. A finished result sits in the output register; the next sample
//   is accepted while it waits, and its result is held back until the
//   receiver has taken the previous beat.
`timescale 1ns / 1ps

module sliding_window_mean_stddev
  import swmsd_pkg::*;
#(
  parameter int unsigned WINDOW = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [23:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [23:0]  window_mean_o,
  output logic [VAR_W-1:0]    window_variance_o,
  output logic [SD_W-1:0]     window_stddev_o
);

  localparam int unsigned ADDR_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned SQ_W   = SQ_TERM_W + $clog2(WINDOW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_SUM_WAIT,
    S_MDIV_GO,
    S_MDIV,
    S_SQ,
    S_SQ_WAIT,
    S_VDIV_GO,
    S_VDIV,
    S_ROOT_GO,
    S_ROOT,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [ADDR_W-1:0]     wr_slot_q;
  logic [ADDR_W-1:0]     idx_q;
  sample_t               mean_q;
  logic [VAR_W-1:0]      var_q;
  logic                  out_valid_q;
  sample_t               out_mean_q;
  logic [VAR_W-1:0]      out_var_q;
  logic [SD_W-1:0]       out_sd_q;

  logic                  in_fire;
  logic                  rd_en;
  logic                  rd_valid;
  sample_t               rd_data;

  logic signed [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0]        sum_mag;
  logic [SQ_W-1:0]         sq_q;
  logic [SAMPLE_W:0]       diff;
  logic [SAMPLE_W-1:0]     abs_d, abs_q;
  logic                    abs_vld_q;
  logic [SQ_TERM_W-1:0]    prod_q;
  logic                    prod_vld_q;

  div_ctrl_t             div_ctrl;
  logic [SQ_W-1:0]       div_num;
  logic                  div_done;
  logic [SQ_W-1:0]       div_quo;
  logic [SUM_W-1:0]      mean_mag;
  logic                  sqrt_done;
  logic [SD_W-1:0]       sqrt_root;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_en      = (state_q == S_SUM) || (state_q == S_SQ);

  // sample ring
  swmsd_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_fire),
    .wr_addr_i  (wr_slot_q),
    .wr_data_i  (sample_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (idx_q),
    .rd_valid_o (rd_valid),
    .rd_data_o  (rd_data)
  );

  // window sum over the first pass
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum_q <= '0;
    end else if (rd_valid && ((state_q == S_SUM) || (state_q == S_SUM_WAIT))) begin
      sum_q <= sum_q + {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
    end
  end

  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // deviation magnitude of each slot from the mean
  always_comb begin
    diff  = {mean_q[SAMPLE_W-1], mean_q} - {rd_data[SAMPLE_W-1], rd_data};
    abs_d = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
  end

  // second pass: deviation, square, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      abs_vld_q  <= rd_valid && ((state_q == S_SQ) || (state_q == S_SQ_WAIT));
      prod_vld_q <= abs_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_q  <= abs_d;
    prod_q <= abs_q * abs_q;
    if (state_q == S_MDIV_GO) begin
      sq_q <= '0;
    end else if (prod_vld_q) begin
      sq_q <= sq_q + {{(SQ_W-SQ_TERM_W){1'b0}}, prod_q};
    end
  end

  // shared divider by WINDOW
  always_comb begin
    div_ctrl.start     = (state_q == S_MDIV_GO) || (state_q == S_VDIV_GO);
    div_ctrl.short_div = (state_q == S_MDIV_GO);
    div_num            = (state_q == S_MDIV_GO) ? {{(SQ_W-SUM_W){1'b0}}, sum_mag} : sq_q;
  end

  swmsd_div #(
    .NUM_W   (SQ_W),
    .SHORT_W (SUM_W),
    .DIVISOR (WINDOW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_num),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // signed mean from quotient magnitude
  assign mean_mag = sum_q[SUM_W-1] ? SUM_W'(-div_quo[SUM_W-1:0]) : div_quo[SUM_W-1:0];

  // square root unit
  swmsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_ROOT_GO),
    .radicand_i (var_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_slot_q   <= '0;
      idx_q       <= '0;
      mean_q      <= '0;
      var_q       <= '0;
      out_valid_q <= 1'b0;
      out_mean_q  <= '0;
      out_var_q   <= '0;
      out_sd_q    <= '0;
    end else begin
      // the done state handles the output register on its own
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            wr_slot_q <= (wr_slot_q == ADDR_W'(WINDOW - 1)) ? '0 : wr_slot_q + 1'b1;
            idx_q     <= '0;
            state_q   <= S_SUM;
          end
        end
        S_SUM: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == ADDR_W'(WINDOW - 1)) begin
            state_q <= S_SUM_WAIT;
          end
        end
        S_SUM_WAIT: begin
          if (!rd_valid) begin
            state_q <= S_MDIV_GO;
          end
        end
        S_MDIV_GO: begin
          state_q <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            mean_q  <= mean_mag[SAMPLE_W-1:0];
            idx_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == ADDR_W'(WINDOW - 1)) begin
            state_q <= S_SQ_WAIT;
          end
        end
        S_SQ_WAIT: begin
          if (!rd_valid && !abs_vld_q && !prod_vld_q) begin
            state_q <= S_VDIV_GO;
          end
        end
        S_VDIV_GO: begin
          state_q <= S_VDIV;
        end
        S_VDIV: begin
          if (div_done) begin
            var_q   <= div_quo[VAR_W-1:0];
            state_q <= S_ROOT_GO;
          end
        end
        S_ROOT_GO: begin
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_mean_q  <= mean_q;
            out_var_q   <= var_q;
            out_sd_q    <= sqrt_root;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign window_mean_o     = out_mean_q;
  assign window_variance_o = out_var_q;
  assign window_stddev_o   = out_sd_q;

endmodule

// ===== hw/rtl/swmsd_ring.sv =====
// swmsd_ring: sample ring storage, one write port and one registered read port.
// Per-entry valid bits make never-written slots read as zero. Uses swmsd_pkg.
`timescale 1ns / 1ps

module swmsd_ring
  import swmsd_pkg::*;
#(
  parameter int unsigned DEPTH  = 20,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  sample_t           wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic              rd_valid_o,
  output sample_t           rd_data_o
);

  sample_t          mem [DEPTH];
  logic [DEPTH-1:0] slot_vld_q;
  sample_t          rd_data_q;
  logic             rd_hit_q;
  logic             rd_valid_q;

  // storage array write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // written-slot flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (wr_en_i) begin
      slot_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      rd_hit_q  <= slot_vld_q[rd_addr_i];
    end
  end

  // read beat strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en_i;
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = rd_hit_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/swmsd_div.sv =====
// swmsd_div: divider by a fixed divisor, one 16-bit quotient digit per cycle.
// Each digit comes from a reciprocal multiply; a short mode skips the leading
// digits of narrow dividends. Uses swmsd_pkg.
`timescale 1ns / 1ps

module swmsd_div
  import swmsd_pkg::*;
#(
  parameter int unsigned NUM_W   = 53,
  parameter int unsigned SHORT_W = 29,
  parameter int unsigned DIVISOR = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctrl_t        ctrl_i,
  input  logic [NUM_W-1:0] dividend_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned DIG_W    = 16;
  localparam int unsigned ND       = (NUM_W + DIG_W - 1) / DIG_W;
  localparam int unsigned SHORT_ND = (SHORT_W + DIG_W - 1) / DIG_W;
  localparam int unsigned PAD_W    = ND * DIG_W;
  localparam int unsigned SHIFT    = PAD_W - SHORT_ND * DIG_W;
  localparam int unsigned REM_W    = $clog2(DIVISOR);
  // partial dividend: running remainder above one digit
  localparam int unsigned PART_W   = REM_W + DIG_W;
  // reciprocal scale, exact floor for every partial dividend
  localparam int unsigned FRAC_W   = PART_W + REM_W;
  localparam int unsigned PROD_W   = 2 * PART_W + 1;
  localparam int unsigned CNT_W    = $clog2(ND + 1);
  localparam logic [PART_W:0] RECIP =
    (PART_W+1)'(((64'd1 << FRAC_W) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PAD_W-1:0]  num_q;
  logic [PAD_W-1:0]  quo_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic [DIG_W-1:0]  digit;
  logic [PART_W-1:0] back;

  // one quotient digit by reciprocal multiply, remainder by back-multiply
  always_comb begin
    part  = {rem_q, num_q[PAD_W-1 -: DIG_W]};
    prod  = PROD_W'(part) * PROD_W'(RECIP);
    digit = prod[FRAC_W +: DIG_W];
    back  = PART_W'(digit) * PART_W'(DIVISOR);
    rem_d = REM_W'(part - back);
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.short_div ? CNT_W'(SHORT_ND) : CNT_W'(ND);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend, remainder and quotient digit shift registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      quo_q <= '0;
      num_q <= ctrl_i.short_div ? (PAD_W'(dividend_i) << SHIFT) : PAD_W'(dividend_i);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= (quo_q << DIG_W) | PAD_W'(digit);
      num_q <= num_q << DIG_W;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[NUM_W-1:0];

endmodule

// ===== hw/rtl/swmsd_sqrt.sv =====
// swmsd_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Uses swmsd_pkg widths.
`timescale 1ns / 1ps

module swmsd_sqrt
  import swmsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAR_W-1:0] radicand_i,
  output logic             done_o,
  output logic [SD_W-1:0]  root_o
);

  localparam int unsigned CNT_W = $clog2(SD_W + 1);

  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_REM_W-1:0] rem_q, rem_d;
  logic [SD_W-1:0]       root_q, root_d;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [ROOT_REM_W+1:0] rem_sh;
  logic [ROOT_REM_W+1:0] trial;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = ROOT_REM_W'(rem_sh - trial);
      root_d = {root_q[SD_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[ROOT_REM_W-1:0];
      root_d = {root_q[SD_W-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // radicand, remainder and root registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {{(RAD_W-VAR_W){1'b0}}, radicand_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== dv/window_stats_checker.sv =====
`timescale 1ns / 1ps
// window_stats_checker: watches the sample and result channels of
// sliding_window_mean_stddev, predicts every result beat and compares it.
// Depends on swmsd_pkg for the sample type and the result widths.

module window_stats_checker
  import swmsd_pkg::*;
#(
  parameter int WINDOW = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  sample_t          sample_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  sample_t          window_mean_i,
  input  logic [VAR_W-1:0] window_variance_i,
  input  logic [SD_W-1:0]  window_stddev_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  typedef struct packed {
    sample_t          mean;
    logic [VAR_W-1:0] variance;
    logic [SD_W-1:0]  stddev;
  } window_stats_t;

  // predictor copy of the sample ring
  sample_t       sample_hist [WINDOW];
  int            next_slot;
  window_stats_t stats_q [$];
  window_stats_t want;
  int            fails   = 0;
  int            checked = 0;

  // floor square root, one result bit per step from the top
  function automatic longint floor_sqrt(input longint radicand);
    longint root;
    longint trial;
    root = 0;
    for (int b = 27; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  // store one sample and work out mean, variance and stddev over the ring
  function automatic window_stats_t push_sample(input sample_t s);
    longint        sum;
    longint        mean;
    longint        dev;
    longint        sq_sum;
    longint        variance;
    longint        root;
    window_stats_t stats;
    sample_hist[next_slot] = s;
    next_slot = (next_slot + 1) % WINDOW;
    sum = 0;
    foreach (sample_hist[i]) sum += longint'(sample_hist[i]);
    // signed division truncates toward zero
    mean = sum / WINDOW;
    sq_sum = 0;
    foreach (sample_hist[i]) begin
      dev = mean - longint'(sample_hist[i]);
      if (dev < 0) dev = -dev;
      sq_sum += dev * dev;
    end
    variance = sq_sum / WINDOW;
    root = floor_sqrt(variance);
    stats.mean     = sample_t'(mean);
    stats.variance = variance[VAR_W-1:0];
    stats.stddev   = root[SD_W-1:0];
    return stats;
  endfunction

  // result beats checked first, then the sample beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (sample_hist[i]) sample_hist[i] = '0;
      next_slot = 0;
      stats_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (stats_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: mean %0d var %0d sd %0d",
                   $time, window_mean_i, window_variance_i, window_stddev_i);
          fails++;
        end else begin
          want = stats_q.pop_front();
          checked++;
          if (window_mean_i !== want.mean) begin
            $display("%0t: window_mean expected %0d got %0d",
                     $time, want.mean, window_mean_i);
            fails++;
          end
          if (window_variance_i !== want.variance) begin
            $display("%0t: window_variance expected %0d got %0d",
                     $time, want.variance, window_variance_i);
            fails++;
          end
          if (window_stddev_i !== want.stddev) begin
            $display("%0t: window_stddev expected %0d got %0d",
                     $time, want.stddev, window_stddev_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) stats_q.insert(stats_q.size(), push_sample(sample_i));
    end
    fail_count_o <= fails;
    pending_o    <= stats_q.size();
    checked_o    <= checked;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives samples into sliding_window_mean_stddev under several
// sender / receiver idle mixes. Depends on swmsd_pkg and window_stats_checker.

module testbench;
  import swmsd_pkg::*;

  localparam int      WINDOW       = 20;
  localparam int      PHASE_ITEMS  = 450;
  localparam int      DRAIN_CYCLES = 400;
  localparam sample_t SAMPLE_MAX   = sample_t'(8388607);
  localparam sample_t SAMPLE_MIN   = sample_t'(-8388608);

  typedef enum int {PAT_NOISE, PAT_CLUSTER, PAT_CORNER, PAT_FLAT} pattern_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  sample_t          sample_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  sample_t          window_mean_o;
  logic [VAR_W-1:0] window_variance_o;
  logic [SD_W-1:0]  window_stddev_o;

  int fail_count;
  int pending;
  int checked;
  int sent       = 0;
  int directed_n = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int ready_left = 0;

  always #10 clk_i = ~clk_i;

  sliding_window_mean_stddev #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_i,
    .out_valid_o,
    .out_ready_i,
    .window_mean_o,
    .window_variance_o,
    .window_stddev_o
  );

  window_stats_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i        (in_ready_o),
    .sample_i,
    .out_valid_i       (out_valid_o),
    .out_ready_i,
    .window_mean_i     (window_mean_o),
    .window_variance_i (window_variance_o),
    .window_stddev_i   (window_stddev_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    return ($urandom_range(7) == 0) ? $urandom_range(100, 350) : $urandom_range(1, 12);
  endfunction

  // receiver: runs of ready and stall, stall share set by the phase
  always @(posedge clk_i) begin
    if (ready_left > 0) begin
      ready_left--;
    end else begin
      ready_left = idle_length();
      out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // one sample beat, with an optional idle gap ahead of it
  task automatic send_sample(input sample_t value);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat (idle_length()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // hold the sender until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // random runs: noise, clusters around a base, corners, flat windows
  task automatic run_random_phase(input int items);
    int       done_n;
    int       run_len;
    int       r;
    pattern_e pat;
    sample_t  base;
    sample_t  value;
    done_n = 0;
    while (done_n < items) begin
      r    = $urandom_range(9);
      pat  = (r < 4) ? PAT_NOISE : (r < 7) ? PAT_CLUSTER : (r < 9) ? PAT_CORNER : PAT_FLAT;
      base = sample_t'($urandom);
      run_len = (pat == PAT_FLAT) ? $urandom_range(WINDOW, WINDOW + 10)
                                  : $urandom_range(1, 25);
      for (int k = 0; k < run_len && done_n < items; k++) begin
        case (pat)
          PAT_NOISE: begin
            value = sample_t'($urandom);
          end
          PAT_CLUSTER: begin
            value = sample_t'(int'(base) + int'($urandom_range(0, 511)) - 256);
          end
          PAT_CORNER: begin
            case ($urandom_range(4))
              0: value = SAMPLE_MAX;
              1: value = SAMPLE_MIN;
              2: value = '0;
              3: value = sample_t'(1);
              default: value = sample_t'(-1);
            endcase
          end
          default: begin
            value = base;
          end
        endcase
        send_sample(value);
        done_n++;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int idle_set [4]  = '{0, 48, 0, 6};
    int stall_set [4] = '{0, 0, 48, 6};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners while the window is still partly empty, then a full
    // alternating max/min window that also wraps the ring
    send_sample('0);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    for (int k = 0; k < WINDOW; k++) send_sample((k % 2) ? SAMPLE_MIN : SAMPLE_MAX);
    directed_n = sent;
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      run_random_phase(PHASE_ITEMS);
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d samples sent: %0d directed corners, the rest random runs over four idle mixes",
             sent, directed_n);
    $display("%0d result beats compared with the predicted mean, variance and stddev",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #(64'd200_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/swmsd_pkg.sv
hw/rtl/swmsd_ring.sv
hw/rtl/swmsd_div.sv
hw/rtl/swmsd_sqrt.sv
hw/rtl/sliding_window_mean_stddev.sv
dv/window_stats_checker.sv
dv/testbench.sv
